[rtl/core/fpq_pkg.sv]
package fpq_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_LE       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } fpq_op_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } fpq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_raw;
        logic                     compare_true;
        logic                     status;
    } fpq_out_t;

    // carried alongside the divider's shifting dividend/quotient word
    typedef struct packed {
        fpq_op_t           op;
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic              dz;
        logic              neg;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] divisor;
    } fpq_ctl_t;

endpackage

[rtl/core/fixed_point_q24_8_alu_unit.sv]
// Signed fixed-point ALU, Q24.8 at the default FRAC_BITS.
//
// Input channel s_valid/s_ready/s_payload carries one transaction per operation:
// func plus two raw 32-bit operands. Output channel m_valid/m_ready/m_payload
// returns exactly one transaction per input, in order: result_raw, compare_true,
// and status (1 on divide by zero, with result_raw forced to 0).
//
// Every operation follows the same pipeline: three front stages (operand
// register, 32x32 multiplier and simple ops, product shift and divider setup),
// then one restoring-divider stage per quotient bit (32 + FRAC_BITS stages),
// then the output register. Throughput is one transaction per cycle while
// the output is not stalled; the divider chain sets the depth.
//
// Reset (aresetn low, synchronous) empties the pipeline and drops m_valid.
// When m_valid is high and m_ready low the whole pipeline freezes and s_ready
// goes low; nothing in flight is lost or repeated.
module fixed_point_q24_8_alu_unit
    import fpq_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fpq_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output fpq_out_t m_payload
);

    localparam int DW = DATA_W + FRAC_BITS;

    logic          pipe_en;
    logic          m_valid_reg;
    fpq_out_t      m_payload_reg;
    fpq_out_t      out_next;

    logic          vld_chain  [DW+1];
    fpq_ctl_t      ctl_chain  [DW+1];
    logic [DW-1:0] work_chain [DW+1];

    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] div_res;
    logic [DATA_W-1:0] raw_res;
    logic [DATA_W-1:0] wrap_res;
    fpq_ctl_t          last_ctl;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    fpq_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_vld  (s_valid),
        .in_data (s_payload),
        .out_vld (vld_chain[0]),
        .out_ctl (ctl_chain[0]),
        .out_work(work_chain[0])
    );

    for (genvar i = 0; i < DW; i++) begin : g_div
        fpq_div_stage #(
            .DW(DW)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .in_vld  (vld_chain[i]),
            .in_ctl  (ctl_chain[i]),
            .in_work (work_chain[i]),
            .out_vld (vld_chain[i+1]),
            .out_ctl (ctl_chain[i+1]),
            .out_work(work_chain[i+1])
        );
    end

    assign last_ctl = ctl_chain[DW];
    assign quo      = work_chain[DW][DATA_W-1:0];
    assign div_res  = last_ctl.dz ? '0 : (last_ctl.neg ? (~quo + 1'b1) : quo);
    assign raw_res  = (last_ctl.op == OP_DIV) ? div_res : last_ctl.res;

    if (WORD_BITS < DATA_W) begin : g_wrap
        assign wrap_res = {{(DATA_W-WORD_BITS){raw_res[WORD_BITS-1]}},
                           raw_res[WORD_BITS-1:0]};
    end else begin : g_nowrap
        assign wrap_res = raw_res;
    end

    always_comb begin
        out_next              = '0;
        out_next.result_raw   = wrap_res;
        out_next.compare_true = last_ctl.cmp;
        out_next.status       = (last_ctl.op == OP_DIV) && last_ctl.dz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= vld_chain[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && vld_chain[DW]) begin
            m_payload_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTHESIS
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status |-> m_payload.result_raw == '0 && !m_payload.compare_true)
        else $error("divide-by-zero transaction carries a nonzero result");

    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.compare_true |-> m_payload.result_raw == '0 && !m_payload.status)
        else $error("comparison transaction carries a result or status");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(vld_chain[DW]) && $stable(vld_chain[0]))
        else $error("pipeline moved while stalled");
`endif

endmodule

[rtl/core/fpq_front.sv]
module fpq_front
    import fpq_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    localparam int DW = DATA_W + FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  fpq_in_t       in_data,
    output logic          out_vld,
    output fpq_ctl_t      out_ctl,
    output logic [DW-1:0] out_work
);

    // stage A: operand register
    logic                     a_vld_reg;
    fpq_op_t                  a_op_reg;
    logic signed [DATA_W-1:0] a_a_reg;
    logic signed [DATA_W-1:0] a_b_reg;

    // stage B: product, simple results, divider setup
    logic                     b_vld_reg;
    fpq_op_t                  b_op_reg;
    logic signed [2*DATA_W-1:0] b_prod_reg;
    logic [DATA_W-1:0]        b_res_reg;
    logic                     b_cmp_reg;
    logic                     b_dz_reg;
    logic                     b_neg_reg;
    logic [DATA_W-1:0]        b_mag_reg;
    logic [DATA_W-1:0]        b_div_reg;

    // stage C
    logic                     c_vld_reg;
    fpq_ctl_t                 c_ctl_reg;
    logic [DW-1:0]            c_work_reg;

    logic signed [2*DATA_W-1:0] prod;
    logic signed [2*DATA_W-1:0] prod_sh;
    logic [DATA_W-1:0]        res_next;
    logic                     cmp_next;
    logic                     lt;
    logic                     eq;
    logic                     gt;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;
    fpq_ctl_t                 ctl_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    assign prod  = a_a_reg * a_b_reg;
    assign lt    = a_a_reg < a_b_reg;
    assign eq    = a_a_reg == a_b_reg;
    assign gt    = !lt && !eq;
    assign mag_a = a_a_reg[DATA_W-1] ? (~a_a_reg + 1'b1) : a_a_reg;
    assign mag_b = a_b_reg[DATA_W-1] ? (~a_b_reg + 1'b1) : a_b_reg;

    always_comb begin
        res_next = '0;
        cmp_next = 1'b0;
        unique case (a_op_reg)
            OP_ADD:      res_next = a_a_reg + a_b_reg;
            OP_SUB:      res_next = a_a_reg - a_b_reg;
            OP_MUL:      res_next = '0;
            OP_DIV:      res_next = '0;
            OP_GT:       cmp_next = gt;
            OP_LT:       cmp_next = lt;
            OP_LE:       cmp_next = lt || eq;
            OP_GE:       cmp_next = !lt;
            OP_EQ:       cmp_next = eq;
            OP_NE:       cmp_next = !eq;
            OP_MIN:      res_next = lt ? a_a_reg : a_b_reg;
            OP_MAX:      res_next = gt ? a_a_reg : a_b_reg;
            OP_INC:      res_next = a_a_reg + 1'b1;
            OP_DEC:      res_next = a_a_reg - 1'b1;
            OP_FROM_INT: res_next = a_a_reg <<< FRAC_BITS;
            OP_TO_INT:   res_next = a_a_reg >>> FRAC_BITS;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (in_vld) begin
                a_op_reg <= fpq_op_t'(in_data.func);
                a_a_reg  <= in_data.operand_a;
                a_b_reg  <= in_data.operand_b;
            end
            if (a_vld_reg) begin
                b_op_reg   <= a_op_reg;
                b_prod_reg <= prod;
                b_res_reg  <= res_next;
                b_cmp_reg  <= cmp_next;
                b_dz_reg   <= (a_b_reg == '0);
                b_neg_reg  <= a_a_reg[DATA_W-1] ^ a_b_reg[DATA_W-1];
                b_mag_reg  <= mag_a;
                b_div_reg  <= mag_b;
            end
            if (b_vld_reg) begin
                c_ctl_reg  <= ctl_next;
                c_work_reg <= {b_mag_reg, {FRAC_BITS{1'b0}}};
            end
        end
    end

    assign prod_sh = b_prod_reg >>> FRAC_BITS;

    always_comb begin
        ctl_next         = '0;
        ctl_next.op      = b_op_reg;
        ctl_next.res     = (b_op_reg == OP_MUL) ? prod_sh[DATA_W-1:0] : b_res_reg;
        ctl_next.cmp     = b_cmp_reg;
        ctl_next.dz      = b_dz_reg;
        ctl_next.neg     = b_neg_reg;
        ctl_next.divisor = b_div_reg;
    end

    assign out_vld  = c_vld_reg;
    assign out_ctl  = c_ctl_reg;
    assign out_work = c_work_reg;

endmodule

[rtl/core/fpq_div_stage.sv]
module fpq_div_stage
    import fpq_pkg::*;
#(
    parameter int DW = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  fpq_ctl_t      in_ctl,
    input  logic [DW-1:0] in_work,
    output logic          out_vld,
    output fpq_ctl_t      out_ctl,
    output logic [DW-1:0] out_work
);

    logic          vld_reg;
    fpq_ctl_t      ctl_reg;
    logic [DW-1:0] work_reg;

    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            fits;
    fpq_ctl_t        ctl_next;
    logic [DW-1:0]   work_next;

    // one restoring step: remainder takes the next dividend bit, quotient bit shifts in
    assign trial = {in_ctl.rem, in_work[DW-1]};
    assign diff  = trial - {1'b0, in_ctl.divisor};
    assign fits  = trial >= {1'b0, in_ctl.divisor};

    always_comb begin
        ctl_next     = in_ctl;
        ctl_next.rem = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        work_next    = {in_work[DW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_vld) begin
            ctl_reg  <= ctl_next;
            work_reg <= work_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_ctl  = ctl_reg;
    assign out_work = work_reg;

endmodule
